// ===== src/chpn_pkg.sv =====
package chpn_pkg;

   localparam int CNT_W = 32;   // bin count and peak width
   localparam int NB_W  = 13;   // active bin count width
   localparam int IDX_W = 12;   // bin index field width
   localparam int NRM_W = 16;   // normalized fraction width
   localparam int FIX_W = 32;   // Q16.16 word width

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CSR_BIN_COUNT = 2'd0,
      CSR_RANGE_MIN = 2'd1,
      CSR_INV_RANGE = 2'd2
   } csr_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAP,
      ST_ADD_WR,
      ST_RD_MEM,
      ST_RD_DATA,
      ST_DIV
   } state_type;

   typedef struct packed {
      logic [FIX_W-1:0] range_min;   // two's complement Q16.16
      logic [FIX_W-1:0] inv_range;
      logic [NB_W-1:0]  nbins;       // already clamped to [2, BINS]
   } map_cfg_type;

   localparam logic [NB_W-1:0]  RST_BIN_COUNT = NB_W'(256);
   localparam logic [FIX_W-1:0] RST_RANGE_MIN = '0;
   localparam logic [FIX_W-1:0] RST_INV_RANGE = FIX_W'(65536);

endpackage

// ===== src/chpn_ram.sv =====
module chpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/chpn_bin_map.sv =====
module chpn_bin_map
   import chpn_pkg::*;
#(
   parameter int AW = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [FIX_W-1:0]  pixel,
   input  map_cfg_type       cfg,
   output logic              out_valid,
   output logic [AW-1:0]     bin
);

   // stage A: offset from range_min
   logic [FIX_W:0]   diff;
   logic             a_valid_ff, a_pos_ff;
   logic [FIX_W-1:0] a_dl_ff;
   // stage B: Q32.32 position
   logic             b_valid_ff, b_pos_ff;
   logic [2*FIX_W-1:0] b_prod_ff;
   // stage C: scale by bin count
   logic             c_valid_ff, c_pos_ff, c_sat_ff;
   logic [FIX_W+NB_W-1:0] c_mul_ff;
   // stage D: clamped bin
   logic             d_valid_ff;
   logic [NB_W-1:0]  d_bin_ff;
   logic [NB_W-1:0]  bin_in;
   logic [NB_W-1:0]  raw_bin;
   logic [NB_W-1:0]  last_bin;

   assign diff = {pixel[FIX_W-1], pixel} - {cfg.range_min[FIX_W-1], cfg.range_min};

   assign raw_bin  = c_mul_ff[FIX_W+NB_W-1:FIX_W];
   assign last_bin = cfg.nbins - NB_W'(1);

   always_comb begin
      if (!c_pos_ff) begin
         bin_in = '0;
      end else if (c_sat_ff || raw_bin >= cfg.nbins) begin
         bin_in = last_bin;
      end else begin
         bin_in = raw_bin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_pos_ff  <= !diff[FIX_W] && (diff != '0) && (cfg.inv_range != '0);
      a_dl_ff   <= diff[FIX_W-1:0];
      b_pos_ff  <= a_pos_ff;
      b_prod_ff <= (2*FIX_W)'(a_dl_ff) * (2*FIX_W)'(cfg.inv_range);
      c_pos_ff  <= b_pos_ff;
      // at or above 1.0 goes to the last bin
      c_sat_ff  <= (b_prod_ff[2*FIX_W-1:FIX_W] != '0);
      c_mul_ff  <= (FIX_W+NB_W)'(b_prod_ff[FIX_W-1:0]) * (FIX_W+NB_W)'(cfg.nbins);
      d_bin_ff  <= bin_in;
   end

   assign out_valid = d_valid_ff;
   assign bin       = d_bin_ff[AW-1:0];

endmodule

// ===== src/chpn_div.sv =====
module chpn_div
   import chpn_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CNT_W-1:0] count,
   input  logic [CNT_W-1:0] peak,
   output logic             done,
   output logic [NRM_W-1:0] quotient
);

   // count*65535/peak by restoring division, one quotient bit a cycle.
   // count <= peak keeps the top 32 dividend bits below peak.
   localparam int STEP_W = $clog2(NRM_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NRM_W - 1);

   logic [CNT_W+NRM_W-1:0] dividend;
   logic [CNT_W-1:0]       rem_ff, rem_in, div_ff;
   logic [NRM_W-1:0]       lo_ff, q_ff;
   logic [STEP_W-1:0]      step_ff;
   logic                   run_ff, done_ff;
   logic [CNT_W:0]         trial, diff;
   logic                   ge;

   assign dividend = {count, NRM_W'(0)} - {NRM_W'(0), count};
   assign trial    = {rem_ff, lo_ff[NRM_W-1]};
   assign diff     = trial - {1'b0, div_ff};
   assign ge       = (trial >= {1'b0, div_ff});
   assign rem_in   = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= run_ff && (step_ff == LAST_STEP);
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[CNT_W+NRM_W-1:NRM_W];
         lo_ff  <= dividend[NRM_W-1:0];
         div_ff <= peak;
         q_ff   <= '0;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         lo_ff  <= {lo_ff[NRM_W-2:0], 1'b0};
         q_ff   <= {q_ff[NRM_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ===== src/clamped_histogram_with_peak_normalize.sv =====
// channel  direction  handshake                 payload
// req      in         start && !busy            req_operation, req_pixel, req_bin_index
// rsp      out        rsp_valid, one cycle      rsp_raw_count, rsp_normalized
// csr      in         csr_valid && csr_ready    csr_index, csr_data
//
// Add: from accept to busy low, 4 bin-map stages, then a RAM read, then a RAM write.
// Read: a RAM read, then the 16-step divider, which is skipped when the peak is zero;
// rsp_valid in the cycle busy drops.
// Clear: one RAM entry zeroed per cycle over all BINS entries; reset runs the same pass.
// One item in flight at a time; csr_ready is always high.
// The receiver cannot stall: rsp_valid is a single-cycle strobe.
module clamped_histogram_with_peak_normalize
   import chpn_pkg::*;
#(
   parameter int BINS = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_operation,
   input  logic signed [FIX_W-1:0] req_pixel,
   input  logic [IDX_W-1:0]        req_bin_index,
   output logic                    rsp_valid,
   output logic [CNT_W-1:0]        rsp_raw_count,
   output logic [NRM_W-1:0]        rsp_normalized,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [FIX_W-1:0]        csr_data
);

   localparam int AW = $clog2(BINS);
   localparam logic [AW-1:0]   LAST_ADDR = AW'(BINS - 1);
   localparam logic [NB_W-1:0] MAX_BINS  = NB_W'(BINS);
   localparam logic [NB_W-1:0] MIN_BINS  = NB_W'(2);

   state_type state_ff, state_in;

   logic [NB_W-1:0]  bin_count_ff;
   logic [FIX_W-1:0] range_min_ff, inv_range_ff;
   logic [NB_W-1:0]  nbins;
   map_cfg_type      map_cfg;

   logic [CNT_W-1:0] peak_ff, peak_in;
   logic [AW-1:0]    clr_addr_ff, clr_addr_in;
   logic [AW-1:0]    addr_ff, addr_in;
   logic [IDX_W-1:0] idx_ff;
   logic             in_range_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] rsp_raw_ff;
   logic [NRM_W-1:0] rsp_norm_ff;

   logic             accept;
   logic             map_start, map_valid;
   logic [AW-1:0]    map_bin;

   logic             mem_we;
   logic [AW-1:0]    mem_waddr, mem_raddr;
   logic [CNT_W-1:0] mem_wdata, mem_rdata;
   logic [CNT_W-1:0] inc_count;

   logic             div_start, div_done;
   logic [NRM_W-1:0] div_q;

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff <= RST_BIN_COUNT;
         range_min_ff <= RST_RANGE_MIN;
         inv_range_ff <= RST_INV_RANGE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BIN_COUNT: bin_count_ff <= csr_data[NB_W-1:0];
            CSR_RANGE_MIN: range_min_ff <= csr_data;
            CSR_INV_RANGE: inv_range_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (bin_count_ff < MIN_BINS) begin
         nbins = MIN_BINS;
      end else if (bin_count_ff > MAX_BINS) begin
         nbins = MAX_BINS;
      end else begin
         nbins = bin_count_ff;
      end
   end

   assign map_cfg.range_min = range_min_ff;
   assign map_cfg.inv_range = inv_range_ff;
   assign map_cfg.nbins     = nbins;

   assign map_start = accept && (req_operation == OP_ADD);

   chpn_bin_map #(.AW(AW)) u_map (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (map_start),
      .pixel     (req_pixel),
      .cfg       (map_cfg),
      .out_valid (map_valid),
      .bin       (map_bin)
   );

   chpn_ram #(.WIDTH(CNT_W), .DEPTH(BINS)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   chpn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .count    (count_in),
      .peak     (peak_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign inc_count = (mem_rdata == '1) ? mem_rdata : mem_rdata + CNT_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_operation)
                  OP_CLEAR: state_in = ST_CLEAR;
                  OP_ADD:   state_in = ST_MAP;
                  OP_READ:  state_in = ST_RD_MEM;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_MAP: begin
            if (map_valid) begin
               state_in = ST_ADD_WR;
            end
         end
         ST_ADD_WR:  state_in = ST_IDLE;
         ST_RD_MEM:  state_in = ST_RD_DATA;
         ST_RD_DATA: state_in = (peak_ff == '0) ? ST_IDLE : ST_DIV;
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      busy         = 1'b1;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = inc_count;
      mem_raddr    = idx_ff[AW-1:0];
      div_start    = 1'b0;
      rsp_valid_in = 1'b0;
      peak_in      = peak_ff;
      clr_addr_in  = clr_addr_ff;
      addr_in      = addr_ff;
      count_in     = in_range_ff ? mem_rdata : '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            peak_in     = '0;
         end
         ST_IDLE: begin
            busy        = 1'b0;
            clr_addr_in = '0;
         end
         ST_MAP: begin
            mem_raddr = map_bin;
            addr_in   = map_bin;
         end
         ST_ADD_WR: begin
            mem_we = 1'b1;
            if (inc_count > peak_ff) begin
               peak_in = inc_count;
            end
         end
         ST_RD_MEM: ;
         ST_RD_DATA: begin
            div_start    = (peak_ff != '0);
            rsp_valid_in = (peak_ff == '0);
         end
         ST_DIV: begin
            rsp_valid_in = div_done;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      if (accept) begin
         idx_ff      <= req_bin_index;
         in_range_ff <= ({1'b0, req_bin_index} < nbins);
      end
      if (state_ff == ST_RD_DATA) begin
         count_ff <= count_in;
      end
      if (rsp_valid_in) begin
         rsp_raw_ff  <= (state_ff == ST_RD_DATA) ? count_in : count_ff;
         rsp_norm_ff <= (state_ff == ST_RD_DATA) ? '0 : div_q;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_raw_count  = rsp_raw_ff;
   assign rsp_normalized = rsp_norm_ff;

endmodule

// ===== src/chpn_checker.sv =====
module chpn_checker
   import chpn_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic [1:0]       req_operation,
   input logic             rsp_valid,
   input logic [CNT_W-1:0] rsp_raw_count,
   input logic [NRM_W-1:0] rsp_normalized
);

   // reset always starts the clearing pass
   a_reset_clears: assert property (@(posedge clock)
      reset |=> busy)
      else $error("not busy after reset");

   a_op_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_operation == OP_CLEAR || req_operation == OP_ADD ||
                          req_operation == OP_READ)) |=> busy)
      else $error("accepted item did not raise busy");

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back results");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

   a_zero_norm: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_raw_count == '0) |-> (rsp_normalized == '0))
      else $error("nonzero fraction for empty bin");

endmodule

bind clamped_histogram_with_peak_normalize chpn_checker u_chk (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_operation  (req_operation),
   .rsp_valid      (rsp_valid),
   .rsp_raw_count  (rsp_raw_count),
   .rsp_normalized (rsp_normalized)
);
